// File: rtl/rsch_pkg.sv
// Shared types, constants and helpers for the ray/sphere closest-hit block.
// No dependencies; imported by ray_sphere_closest_hit_top.
`default_nettype none

package rsch_pkg;

  // Fixed-point format of coordinates, radii and distances
  localparam int FRAC_BITS = 16;

  // Width of the shared datapath and of the serial multiplier operand
  localparam int ACCW = 144;
  localparam int OPW  = 72;

  // Result normal field width
  localparam int NORMW = 18;

  // Squared-length threshold for a normal of length 0.0001 or less
  localparam logic [63:0] NORM_THR = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

  // 1.0 in the fixed-point format
  localparam logic [32:0] NORM_ONE   = 33'(64'd1 << FRAC_BITS);
  localparam logic [30:0] MAXD_RESET = 31'(64'd1 << FRAC_BITS);

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_MAX_DIST = 3'd6;

  typedef logic signed [ACCW-1:0] acc_t;

  localparam acc_t S32_MAX = acc_t'(64'sh7FFFFFFF);
  localparam acc_t S32_MIN = -acc_t'(64'sh80000000);

  function automatic acc_t abs_acc(acc_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(acc_t v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ray_sphere_closest_hit_top.sv
// Closest-hit ray cast against a stream of spheres, one shared serial unit.
// Depends on rsch_pkg.
`default_nettype none
// Usage:
//   The ray origin, direction and distance limit are written through the
//   cfg_write / cfg_index / cfg_data port while the block is idle.
//   Each input word on in_valid/in_ready is one sphere; the word with last
//   set closes the query and produces exactly one result word on
//   out_valid/out_ready (hit flag, id, distance, hit point, unit normal).
//   All arithmetic runs on one 144-bit add/compare/shift unit: bit-serial
//   multiply-accumulate (stops when the multiplier bits run out), a
//   restoring square root (72 steps) and a restoring divide (33 steps).
//   An active sphere runs the full test; an inactive one skips to the end step.
//   On a last word with a hit, the hit point and normal are computed as well.
//   in_ready is high only while the sequencer is idle; one word at a time.
//   The result sits in an output register; the next query may be accepted
//   while it waits. A finished result holds the sequencer until the
//   previous one has been taken.
//   Synchronous reset clears the registers to origin 0, direction 0,
//   limit 1.0, and drops out_valid.

module ray_sphere_closest_hit_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [2:0]                          cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  center_x,
  input  logic signed [31:0]                  center_y,
  input  logic signed [31:0]                  center_z,
  input  logic [30:0]                         radius,
  input  logic [31:0]                         sphere_id,
  input  logic                                active,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit_found,
  output logic [31:0]                         hit_id,
  output logic [30:0]                         hit_range,
  output logic signed [31:0]                  hit_x,
  output logic signed [31:0]                  hit_y,
  output logic signed [31:0]                  hit_z,
  output logic signed [rsch_pkg::NORMW-1:0]   normal_x,
  output logic signed [rsch_pkg::NORMW-1:0]   normal_y,
  output logic signed [rsch_pkg::NORMW-1:0]   normal_z
);
  import rsch_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ISSUE  = 3'd1;
  localparam logic [2:0] ST_MAC    = 3'd2;
  localparam logic [2:0] ST_SQRT   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_RETIRE = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // Operation kinds of the shared unit
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_MAC  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;
  localparam logic [1:0] OP_DIV  = 2'd3;

  // Program steps: sphere test, then result on a last word
  localparam logic [4:0] SP_A0  = 5'd0;
  localparam logic [4:0] SP_A1  = 5'd1;
  localparam logic [4:0] SP_A2  = 5'd2;
  localparam logic [4:0] SP_H0  = 5'd3;
  localparam logic [4:0] SP_H1  = 5'd4;
  localparam logic [4:0] SP_H2  = 5'd5;
  localparam logic [4:0] SP_C0  = 5'd6;
  localparam logic [4:0] SP_C1  = 5'd7;
  localparam logic [4:0] SP_C2  = 5'd8;
  localparam logic [4:0] SP_CR  = 5'd9;
  localparam logic [4:0] SP_D0  = 5'd10;
  localparam logic [4:0] SP_D1  = 5'd11;
  localparam logic [4:0] SP_SQ  = 5'd12;
  localparam logic [4:0] SP_T1  = 5'd13;
  localparam logic [4:0] SP_T2  = 5'd14;
  localparam logic [4:0] SP_UPD = 5'd15;
  localparam logic [4:0] SP_END = 5'd16;
  localparam logic [4:0] SP_P0  = 5'd17;
  localparam logic [4:0] SP_P1  = 5'd18;
  localparam logic [4:0] SP_P2  = 5'd19;
  localparam logic [4:0] SP_S0  = 5'd20;
  localparam logic [4:0] SP_S1  = 5'd21;
  localparam logic [4:0] SP_S2  = 5'd22;
  localparam logic [4:0] SP_L   = 5'd23;
  localparam logic [4:0] SP_N0  = 5'd24;
  localparam logic [4:0] SP_N1  = 5'd25;
  localparam logic [4:0] SP_N2  = 5'd26;
  localparam logic [4:0] SP_OUT = 5'd27;

  // Configuration registers
  logic signed [31:0] ray_o [3];
  logic signed [31:0] ray_d [3];
  logic [30:0]        t_limit;

  // Running best
  logic [30:0]        best_t;
  logic [31:0]        best_id;
  logic               best_found;
  logic signed [31:0] best_c [3];

  // Current sphere
  logic signed [32:0] oc [3];
  logic signed [31:0] cur_c [3];
  logic [30:0]        cur_r;
  logic [31:0]        cur_id;
  logic               cur_last;

  // Quadratic terms
  logic [63:0]        av;
  logic signed [67:0] hv;
  logic signed [67:0] cv;
  acc_t               dv;
  logic [67:0]        sv;
  logic [32:0]        tv;

  // Result terms
  logic signed [31:0]       hit [3];
  logic signed [32:0]       vv [3];
  logic [67:0]              ssum;
  logic [33:0]              lv;
  logic signed [NORMW-1:0]  nq [3];

  // Sequencer and shared unit
  logic [2:0]     state;
  logic [4:0]     step;
  logic [1:0]     lane;
  acc_t           wa;
  acc_t           wb;
  acc_t           wc;
  acc_t           base;
  acc_t           res;
  logic [OPW-1:0] my;
  logic           mneg;
  logic [5:0]     cnt;

  logic [1:0] op_kind;
  acc_t       op_x;
  acc_t       op_y;
  acc_t       op_base;

  acc_t               mac_sum;
  acc_t               sq_trial;
  logic               sq_take;
  logic               div_take;
  acc_t               hit_sum;
  logic signed [31:0] hit_new;
  logic signed [32:0] vv_new;
  logic [32:0]        nq_mag;
  logic signed [NORMW-1:0] nq_new;

  assign in_ready = (state == ST_IDLE);

  // Vector lane of the current step
  always_comb begin
    case (step)
      SP_A1, SP_H1, SP_C1, SP_P1, SP_S1, SP_N1: lane = 2'd1;
      SP_A2, SP_H2, SP_C2, SP_P2, SP_S2, SP_N2: lane = 2'd2;
      default:                                  lane = 2'd0;
    endcase
  end

  // Operand selection for the step being issued
  always_comb begin
    op_kind = OP_NONE;
    op_x    = '0;
    op_y    = '0;
    op_base = '0;
    case (step)
      SP_A0, SP_A1, SP_A2: begin
        op_kind = OP_MAC;
        op_x    = acc_t'(ray_d[lane]);
        op_y    = acc_t'(ray_d[lane]);
        op_base = (step == SP_A0) ? '0 : acc_t'(av);
      end
      SP_H0, SP_H1, SP_H2: begin
        op_kind = OP_MAC;
        op_x    = acc_t'(oc[lane]);
        op_y    = acc_t'(ray_d[lane]);
        op_base = (step == SP_H0) ? '0 : acc_t'(hv);
      end
      SP_C0, SP_C1, SP_C2: begin
        op_kind = OP_MAC;
        op_x    = acc_t'(oc[lane]);
        op_y    = acc_t'(oc[lane]);
        op_base = (step == SP_C0) ? '0 : acc_t'(cv);
      end
      SP_CR: begin
        op_kind = OP_MAC;
        op_x    = -acc_t'(cur_r);
        op_y    = acc_t'(cur_r);
        op_base = acc_t'(cv);
      end
      SP_D0: begin
        op_kind = OP_MAC;
        op_x    = acc_t'(hv);
        op_y    = acc_t'(hv);
      end
      SP_D1: begin
        op_kind = OP_MAC;
        op_x    = -acc_t'(av);
        op_y    = acc_t'(cv);
        op_base = dv;
      end
      SP_SQ: begin
        op_kind = OP_SQRT;
        op_x    = dv;
      end
      SP_T1: begin
        op_kind = OP_DIV;
        op_x    = (-acc_t'(hv) - acc_t'(sv)) <<< FRAC_BITS;
        op_y    = acc_t'(av);
      end
      SP_T2: begin
        op_kind = OP_DIV;
        op_x    = (-acc_t'(hv) + acc_t'(sv)) <<< FRAC_BITS;
        op_y    = acc_t'(av);
      end
      SP_P0, SP_P1, SP_P2: begin
        op_kind = OP_MAC;
        op_x    = acc_t'(ray_d[lane]);
        op_y    = acc_t'(best_t);
      end
      SP_S0, SP_S1, SP_S2: begin
        op_kind = OP_MAC;
        op_x    = acc_t'(vv[lane]);
        op_y    = acc_t'(vv[lane]);
        op_base = (step == SP_S0) ? '0 : acc_t'(ssum);
      end
      SP_L: begin
        op_kind = OP_SQRT;
        op_x    = acc_t'(ssum);
      end
      SP_N0, SP_N1, SP_N2: begin
        op_kind = OP_DIV;
        op_x    = abs_acc(acc_t'(vv[lane])) <<< FRAC_BITS;
        op_y    = acc_t'(lv);
      end
      default: op_kind = OP_NONE;
    endcase
  end

  // Shared unit datapath
  assign mac_sum  = wb + (my[0] ? wa : '0);
  assign sq_trial = wb + wc;
  assign sq_take  = (wa >= sq_trial);
  assign div_take = (wa >= wb);

  // Hit point and normal component from the last result
  assign hit_sum = acc_t'(ray_o[lane]) + (res >>> FRAC_BITS);
  assign hit_new = sat32(hit_sum);
  assign vv_new  = {hit_new[31], hit_new} - {best_c[lane][31], best_c[lane]};
  assign nq_mag  = (res > acc_t'(NORM_ONE)) ? NORM_ONE : res[32:0];
  assign nq_new  = vv[lane][32] ? NORMW'(-nq_mag) : NORMW'(nq_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= SP_A0;
      out_valid    <= 1'b0;
      ray_o[0]     <= '0;
      ray_o[1]     <= '0;
      ray_o[2]     <= '0;
      ray_d[0]     <= '0;
      ray_d[1]     <= '0;
      ray_d[2]     <= '0;
      t_limit      <= MAXD_RESET;
      best_t       <= MAXD_RESET;
      best_id      <= '0;
      best_found   <= 1'b0;
      best_c[0]    <= '0;
      best_c[1]    <= '0;
      best_c[2]    <= '0;
    end else begin
      // Result word handshake
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_ORIGIN_X: ray_o[0] <= cfg_data;
          REG_ORIGIN_Y: ray_o[1] <= cfg_data;
          REG_ORIGIN_Z: ray_o[2] <= cfg_data;
          REG_DIR_X:    ray_d[0] <= cfg_data;
          REG_DIR_Y:    ray_d[1] <= cfg_data;
          REG_DIR_Z:    ray_d[2] <= cfg_data;
          REG_MAX_DIST: begin
            t_limit <= cfg_data[30:0];
            if (!best_found) begin
              best_t <= cfg_data[30:0];
            end
          end
          default: ;
        endcase
      end

      case (state)
        // Take a sphere word
        ST_IDLE: begin
          if (in_valid) begin
            oc[0]    <= {ray_o[0][31], ray_o[0]} - {center_x[31], center_x};
            oc[1]    <= {ray_o[1][31], ray_o[1]} - {center_y[31], center_y};
            oc[2]    <= {ray_o[2][31], ray_o[2]} - {center_z[31], center_z};
            cur_c[0] <= center_x;
            cur_c[1] <= center_y;
            cur_c[2] <= center_z;
            cur_r    <= radius;
            cur_id   <= sphere_id;
            cur_last <= last;
            step     <= active ? SP_A0 : SP_END;
            state    <= ST_ISSUE;
          end
        end

        // Launch the step's operation, or do its bookkeeping
        ST_ISSUE: begin
          case (op_kind)
            OP_MAC: begin
              wa    <= abs_acc(op_x);
              my    <= OPW'(abs_acc(op_y));
              mneg  <= op_x[ACCW-1] ^ op_y[ACCW-1];
              wb    <= '0;
              base  <= op_base;
              state <= ST_MAC;
            end
            OP_SQRT: begin
              wa    <= op_x;
              wb    <= '0;
              wc    <= acc_t'(1) <<< (ACCW - 2);
              state <= ST_SQRT;
            end
            OP_DIV: begin
              if (op_x <= 0) begin
                res   <= '0;
                state <= ST_RETIRE;
              end else begin
                wa    <= op_x;
                wb    <= op_y <<< 32;
                wc    <= '0;
                cnt   <= 6'd32;
                state <= ST_DIV;
              end
            end
            default: begin
              case (step)
                SP_UPD: begin
                  if (tv != '0 && tv <= {2'b00, best_t}) begin
                    best_t     <= tv[30:0];
                    best_id    <= cur_id;
                    best_found <= 1'b1;
                    best_c     <= cur_c;
                  end
                  step <= SP_END;
                end
                SP_END: begin
                  if (cur_last) begin
                    nq[0] <= '0;
                    nq[1] <= '0;
                    nq[2] <= '0;
                    step  <= best_found ? SP_P0 : SP_OUT;
                  end else begin
                    state <= ST_IDLE;
                  end
                end
                SP_OUT:  state <= ST_OUT;
                default: state <= ST_IDLE;
              endcase
            end
          endcase
        end

        // Bit-serial multiply-accumulate
        ST_MAC: begin
          if (my == '0) begin
            res   <= mneg ? (base - wb) : (base + wb);
            state <= ST_RETIRE;
          end else begin
            wb <= mac_sum;
            wa <= wa <<< 1;
            my <= my >> 1;
          end
        end

        // Restoring square root, one result bit per cycle
        ST_SQRT: begin
          if (wc == '0) begin
            res   <= wb;
            state <= ST_RETIRE;
          end else begin
            if (sq_take) begin
              wa <= wa - sq_trial;
              wb <= (wb >>> 1) + wc;
            end else begin
              wb <= wb >>> 1;
            end
            wc <= wc >>> 2;
          end
        end

        // Restoring divide, quotient saturates at 2^32
        ST_DIV: begin
          if (cnt == 6'd32) begin
            if (div_take) begin
              res   <= acc_t'(1) <<< 32;
              state <= ST_RETIRE;
            end else begin
              cnt <= 6'd31;
              wb  <= wb >>> 1;
            end
          end else begin
            if (div_take) begin
              wa <= wa - wb;
            end
            wc <= (wc <<< 1) | acc_t'(div_take);
            wb <= wb >>> 1;
            if (cnt == 6'd0) begin
              res   <= (wc <<< 1) | acc_t'(div_take);
              state <= ST_RETIRE;
            end else begin
              cnt <= cnt - 6'd1;
            end
          end
        end

        // Store the result and pick the next step
        ST_RETIRE: begin
          state <= ST_ISSUE;
          step  <= step + 5'd1;
          case (step)
            SP_A0, SP_A1, SP_A2: av <= res[63:0];
            SP_H0, SP_H1, SP_H2: hv <= res[67:0];
            SP_C0, SP_C1, SP_C2: cv <= res[67:0];
            SP_CR: begin
              cv <= res[67:0];
              if (av == '0) begin
                step <= SP_END;
              end
            end
            SP_D0: dv <= res;
            SP_D1: begin
              dv <= res;
              if (res < 0) begin
                step <= SP_END;
              end
            end
            SP_SQ: sv <= res[67:0];
            SP_T1: begin
              tv   <= res[32:0];
              step <= (res == '0) ? SP_T2 : SP_UPD;
            end
            SP_T2: tv <= res[32:0];
            SP_P0, SP_P1, SP_P2: begin
              hit[lane] <= hit_new;
              vv[lane]  <= vv_new;
            end
            SP_S0, SP_S1: ssum <= res[67:0];
            SP_S2: begin
              ssum <= res[67:0];
              step <= (res > acc_t'(NORM_THR)) ? SP_L : SP_OUT;
            end
            SP_L: begin
              lv <= res[33:0];
              if (res == '0) begin
                step <= SP_OUT;
              end
            end
            SP_N0, SP_N1, SP_N2: nq[lane] <= nq_new;
            default: ;
          endcase
        end

        // Hand the result to the output register, then clear the best
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            hit_found    <= best_found;
            hit_id       <= best_id;
            hit_range    <= best_found ? best_t : '0;
            hit_x        <= best_found ? hit[0] : '0;
            hit_y        <= best_found ? hit[1] : '0;
            hit_z        <= best_found ? hit[2] : '0;
            normal_x     <= nq[0];
            normal_y     <= nq[1];
            normal_z     <= nq[2];
            best_t       <= t_limit;
            best_id      <= '0;
            best_found   <= 1'b0;
            best_c[0]    <= '0;
            best_c[1]    <= '0;
            best_c[2]    <= '0;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/rsch_check.sv
// Port-level checks for ray_sphere_closest_hit_top, attached by bind.
// No package dependency.
`default_nettype none

module rsch_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit_found,
  input logic [31:0] hit_id,
  input logic [30:0] hit_range
);

  // Reset drops the result word
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // An accepted sphere word always leaves the sequencer busy in the following cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready right after accept");

  // A result only appears while the sequencer is busy
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word from idle sequencer");

  // A miss reports zero id and distance
  a_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit_found) |-> (hit_id == '0 && hit_range == '0))
    else $error("miss with nonzero fields");

  // Stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hit_id)))
    else $error("result word changed while stalled");

endmodule

bind ray_sphere_closest_hit_top rsch_check u_rsch_check (.*);

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for ray_sphere_closest_hit_top: exact-width closest-hit
// predictor in a scoreboard class, directed and random sphere streams, random stalls.
// Depends on rsch_pkg and the RTL of ray_sphere_closest_hit_top.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsch_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] cx, cy, cz;
    logic [30:0]        radius;
    logic [31:0]        id;
    logic               active;
    logic               last;
  } sphere_t;

  typedef struct {
    logic                    found;
    logic [31:0]             id;
    logic [30:0]             tval;
    logic signed [31:0]      hx, hy, hz;
    logic signed [NORMW-1:0] nx, ny, nz;
  } hit_t;

  localparam int WDOG_LIMIT = 40000;
  localparam logic signed [31:0] ONE = 32'sd65536;

  // Closest-hit predictor and queue of pending query results
  class hit_scoreboard;
    logic signed [31:0] org[3];
    logic signed [31:0] dir[3];
    logic [30:0]        maxd;
    logic [63:0]        best_t;
    logic [31:0]        best_id;
    logic               best_found;
    logic signed [31:0] best_c[3];
    hit_t               pending_hits[$];
    int                 errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        org[i] = 0;
        dir[i] = 0;
      end
      maxd   = MAXD_RESET;
      errors = 0;
      clear_best();
    endfunction

    function void clear_best();
      best_t     = {33'd0, maxd};
      best_id    = 0;
      best_found = 0;
      for (int i = 0; i < 3; i++) best_c[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_ORIGIN_X: org[0] = val;
        REG_ORIGIN_Y: org[1] = val;
        REG_ORIGIN_Z: org[2] = val;
        REG_DIR_X:    dir[0] = val;
        REG_DIR_Y:    dir[1] = val;
        REG_DIR_Z:    dir[2] = val;
        REG_MAX_DIST: begin
          maxd = val[30:0];
          if (!best_found) best_t = {33'd0, maxd};
        end
        default: ;
      endcase
    endfunction

    function wide_t isqrt(wide_t x);
      logic [255:0] r, c, ux;
      ux = x;
      r  = 0;
      for (int k = 127; k >= 0; k--) begin
        c = r | (256'd1 << k);
        if (c * c <= ux) r = c;
      end
      return wide_t'(r);
    endfunction

    function logic [63:0] root_of(wide_t num, wide_t a);
      wide_t q;
      if (num <= 0) return 0;
      q = (num <<< FRAC_BITS) / a;
      if (q >= (wide_t'(1) <<< 32)) return 64'd1 << 32;
      return q[63:0];
    endfunction

    function void test_sphere(sphere_t s);
      wide_t a, h, cc, oc, disc, rt;
      logic signed [31:0] c[3];
      logic [63:0] t;
      c[0] = s.cx; c[1] = s.cy; c[2] = s.cz;
      a = 0; h = 0; cc = 0;
      for (int i = 0; i < 3; i++) begin
        oc = wide_t'(org[i]) - wide_t'(c[i]);
        a  = a + wide_t'(dir[i]) * wide_t'(dir[i]);
        h  = h + oc * wide_t'(dir[i]);
        cc = cc + oc * oc;
      end
      cc = cc - wide_t'(s.radius) * wide_t'(s.radius);
      if (a == 0) return;
      disc = h * h - a * cc;
      if (disc < 0) return;
      rt = isqrt(disc);
      t  = root_of(-h - rt, a);
      if (t == 0) t = root_of(-h + rt, a);
      if (t == 0 || t > best_t) return;
      best_t     = t;
      best_id    = s.id;
      best_found = 1;
      best_c     = c;
    endfunction

    function hit_t closest_hit();
      hit_t r;
      wide_t hv, v[3], sq, len, q;
      logic signed [31:0] hp[3];
      logic signed [NORMW-1:0] n[3];
      r = '{default: '0};
      if (!best_found) return r;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        hv = wide_t'(org[i]) + ((wide_t'(dir[i]) * wide_t'(best_t)) >>> FRAC_BITS);
        if (hv > wide_t'(32'sh7FFFFFFF)) hv = wide_t'(32'sh7FFFFFFF);
        if (hv < wide_t'(32'sh80000000)) hv = wide_t'(32'sh80000000);
        hp[i] = hv[31:0];
        v[i]  = wide_t'(hp[i]) - wide_t'(best_c[i]);
        sq    = sq + v[i] * v[i];
        n[i]  = 0;
      end
      if (sq > wide_t'(NORM_THR)) begin
        len = isqrt(sq);
        for (int i = 0; i < 3; i++) begin
          q = (((v[i] < 0) ? -v[i] : v[i]) <<< FRAC_BITS) / len;
          if (q > wide_t'(NORM_ONE)) q = wide_t'(NORM_ONE);
          if (v[i] < 0) q = -q;
          n[i] = q[NORMW-1:0];
        end
      end
      r.found = 1;
      r.id    = best_id;
      r.tval  = best_t[30:0];
      r.hx = hp[0]; r.hy = hp[1]; r.hz = hp[2];
      r.nx = n[0];  r.ny = n[1];  r.nz = n[2];
      return r;
    endfunction

    // Accepted sphere word: update running best, queue a result on last
    function void note_sphere(sphere_t s);
      if (s.active) test_sphere(s);
      if (s.last) begin
        pending_hits.push_back(closest_hit());
        clear_best();
      end
    endfunction

    function int pending();
      return pending_hits.size();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t MISMATCH %s: got %h want %h", $realtime, what, got, want);
    endtask

    task check(hit_t got);
      hit_t w;
      if (pending_hits.size() == 0) begin
        report("unexpected result word", got.id, 0);
        return;
      end
      w = pending_hits.pop_front();
      if (got.found !== w.found) report("hit_found", got.found, w.found);
      if (got.id !== w.id) report("hit_id", got.id, w.id);
      if (got.tval !== w.tval) report("hit_range", got.tval, w.tval);
      if (got.hx !== w.hx) report("hit_x", got.hx, w.hx);
      if (got.hy !== w.hy) report("hit_y", got.hy, w.hy);
      if (got.hz !== w.hz) report("hit_z", got.hz, w.hz);
      if (got.nx !== w.nx) report("normal_x", got.nx, w.nx);
      if (got.ny !== w.ny) report("normal_y", got.ny, w.ny);
      if (got.nz !== w.nz) report("normal_z", got.nz, w.nz);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = REG_ORIGIN_X;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] center_x = 0, center_y = 0, center_z = 0;
  logic [30:0] radius = 0;
  logic [31:0] sphere_id = 0;
  logic active = 0, last = 0;
  logic out_valid;
  logic out_ready = 0;
  logic hit_found;
  logic [31:0] hit_id;
  logic [30:0] hit_range;
  logic signed [31:0] hit_x, hit_y, hit_z;
  logic signed [NORMW-1:0] normal_x, normal_y, normal_z;

  hit_scoreboard sb = new();
  bit calm = 0;
  int idle_cycles = 0;
  int sent = 0;

  ray_sphere_closest_hit_top dut (.*);

  always #2 clk = ~clk;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic sphere_t mk(logic signed [31:0] cx, cy, cz, logic [30:0] r,
                                 logic [31:0] id, logic act, logic lst);
    sphere_t s;
    s.cx = cx; s.cy = cy; s.cz = cz; s.radius = r;
    s.id = id; s.active = act; s.last = lst;
    return s;
  endfunction

  // Drive one sphere word; valid stays high into the next call when no gap
  task send_sphere(sphere_t s);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1;
    center_x  <= s.cx;
    center_y  <= s.cy;
    center_z  <= s.cz;
    radius    <= s.radius;
    sphere_id <= s.id;
    active    <= s.active;
    last      <= s.last;
    do @(posedge clk); while (!in_ready);
    sb.note_sphere(s);
    sent++;
  endtask

  // Stop sending and wait for every pending result, then let the block settle
  task drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_write after its last write
  task write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task write_ray(logic [31:0] ox, oy, oz, dx, dy, dz, md);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_MAX_DIST, md);
    cfg_write <= 0;
  endtask

  function automatic logic signed [31:0] srand(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Sphere near the current ray so that most queries see hits
  function automatic sphere_t sphere_on_ray(logic lst);
    sphere_t s;
    longint t0, c[3];
    t0 = $urandom_range(0, 30 * 65536);
    for (int i = 0; i < 3; i++)
      c[i] = longint'(sb.org[i]) + ((longint'(sb.dir[i]) * t0) >>> 16)
             + longint'(srand(65536));
    s = mk(c[0][31:0], c[1][31:0], c[2][31:0], 31'($urandom_range(0, 3 * 65536)),
           $urandom_range(1, 32'hFFFF_FFFF), ($urandom_range(0, 9) != 0), lst);
    if ($urandom_range(0, 7) == 0) s = mk(s.cx, s.cy, s.cz, s.radius, s.id, s.active, lst);
    return s;
  endfunction

  function automatic sphere_t noise_sphere(logic lst);
    return mk($urandom, $urandom, $urandom, 31'($urandom),
              $urandom_range(1, 32'hFFFF_FFFF), 1'($urandom_range(0, 1)), lst);
  endfunction

  // Result side: random stalls, check on every accepted result word
  initial begin
    hit_t got;
    int stall;
    @(negedge rst);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      got.found = hit_found; got.id = hit_id; got.tval = hit_range;
      got.hx = hit_x; got.hy = hit_y; got.hz = hit_z;
      got.nx = normal_x; got.ny = normal_y; got.nz = normal_z;
      sb.check(got);
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int nq;
    logic [31:0] md;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset registers: zero direction, nothing can hit
    send_sphere(mk(0, 0, 0, 31'(ONE), 5, 1, 0));
    send_sphere(mk(32'sh7FFFFFFF, 32'sh80000000, 0, 31'h7FFFFFFF, 6, 1, 1));
    drain();

    // Ray along +x, limit 100.0
    write_ray(0, 0, 0, ONE, 0, 0, 100 * ONE);
    // Tie at t = 9: later sphere wins; inactive extreme last word
    send_sphere(mk(10 * ONE, 0, 0, 31'(ONE), 11, 1, 0));
    send_sphere(mk(10 * ONE, 0, 0, 31'(ONE), 12, 1, 0));
    send_sphere(mk(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF,
                   32'hFFFF_FFFF, 0, 1));
    // Origin inside the sphere: far root
    send_sphere(mk(0, 0, 0, 31'(2 * ONE), 21, 1, 1));
    // Negative discriminant and a sphere behind the origin
    send_sphere(mk(5 * ONE, 5 * ONE, 0, 31'(ONE), 31, 1, 0));
    send_sphere(mk(-10 * ONE, 0, 0, 31'(ONE), 32, 1, 1));
    // Past the limit, then extreme center with largest radius
    send_sphere(mk(200 * ONE, 0, 0, 31'(ONE), 41, 1, 0));
    send_sphere(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 42, 1, 1));
    // Zero radius, tangent touch
    send_sphere(mk(5 * ONE, 0, 0, 0, 51, 1, 1));
    drain();

    // Extreme ray registers, largest limit
    write_ray(32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'h7FFFFFFF, 1, 32'h7FFFFFFF);
    send_sphere(mk(0, 0, 0, 31'h7FFFFFFF, 61, 1, 0));
    send_sphere(mk(32'sh7FFFFFFF, 32'sh80000000, 0, 31'(ONE), 62, 1, 0));
    send_sphere(noise_sphere(1));
    drain();

    // Smallest limit: nothing fits
    write_ray(0, 0, 0, ONE, ONE, 0, 1);
    send_sphere(mk(10 * ONE, 10 * ONE, 0, 31'(2 * ONE), 71, 1, 1));
    drain();

    // Random phases
    while (sent < 500) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0:       md = $urandom_range(1, 32'h7FFFFFFF);
        1:       md = 32'h7FFFFFFF;
        2:       md = $urandom_range(1, 65536);
        default: md = $urandom_range(ONE, 40 * ONE);
      endcase
      if ($urandom_range(0, 7) == 0) begin
        write_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, md);
      end else begin
        write_ray(srand(10 * ONE), srand(10 * ONE), srand(10 * ONE),
                  ($urandom_range(0, 5) == 0) ? 0 : srand(2 * ONE),
                  ($urandom_range(0, 5) == 0) ? 0 : srand(2 * ONE),
                  ($urandom_range(0, 5) == 0) ? 0 : srand(2 * ONE), md);
      end
      repeat ($urandom_range(2, 6)) begin
        nq = $urandom_range(1, 6);
        for (int k = 0; k < nq; k++) begin
          if ($urandom_range(0, 6) == 0) send_sphere(noise_sphere(k == nq - 1));
          else send_sphere(sphere_on_ray(k == nq - 1));
        end
      end
      drain();
    end

    calm = 0;
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/rsch_pkg.sv
rtl/ray_sphere_closest_hit_top.sv
rtl/rsch_check.sv
sim/tb.sv
